// File: rtl/core/multi_stop_color_gradient_core_defines.svh
// Assertion macros used by the interpolation RTL (mscg_lerp) of the gradient core.
`ifndef MULTI_STOP_COLOR_GRADIENT_CORE_DEFINES_SVH
`define MULTI_STOP_COLOR_GRADIENT_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while arst_n is low.
`define MSCG_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, sampled on clk and disabled while arst_n is low.
`define MSCG_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// File: rtl/core/mscg_pkg.sv
// Shared constants and types of the gradient core.
package mscg_pkg;
	localparam int MaxStops = 6;
	localparam int PosW     = 16;
	localparam int ChanW    = 8;
	localparam int NumCh    = 4;
	localparam int ColW     = ChanW * NumCh;
	localparam int StopW    = PosW + ColW;
	localparam int CfgIdxW  = 3;
	localparam int CountW   = 3;
	localparam int ProdW    = PosW + ChanW;
	localparam int ValW     = ProdW + 2;
	localparam int RemW     = ValW + 1;
	localparam int DivSteps = ChanW;

	localparam logic [CfgIdxW-1:0] RegCount = 3'd0;
	localparam logic [CfgIdxW-1:0] RegStop0 = 3'd1;

	typedef struct packed {
		logic [ColW-1:0] ca;
		logic [ColW-1:0] cb;
		logic [PosW-1:0] num;
		logic [PosW-1:0] den;
	} lerp_req_t;
endpackage

// File: rtl/core/mscg_if.sv
// Request channel interfaces for positions and colours.
interface mscg_pos_if import mscg_pkg::*; ();
	logic            valid;
	logic            ready;
	logic [PosW-1:0] position;
	modport source(output valid, output position, input ready);
	modport sink(input valid, input position, output ready);
endinterface

interface mscg_color_if import mscg_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [ChanW-1:0] red;
	logic [ChanW-1:0] green;
	logic [ChanW-1:0] blue;
	logic [ChanW-1:0] alpha;
	modport source(output valid, output red, output green, output blue, output alpha,
		input ready);
	modport sink(input valid, input red, input green, input blue, input alpha,
		output ready);
endinterface

// File: rtl/core/mscg_select.sv
// Stop registers and the two stages that pick the segment for a position.
module mscg_select import mscg_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_en,
	input  logic [CfgIdxW-1:0] wr_index,
	input  logic [StopW-1:0]   wr_data,
	mscg_pos_if.sink           pos,
	output logic               req_valid,
	input  logic               req_ready,
	output lerp_req_t          req
);
	logic [CountW-1:0] count_q;
	logic [StopW-1:0]  stop_q [MaxStops];
	logic [PosW-1:0]   sp     [MaxStops];
	logic [ColW-1:0]   sc     [MaxStops];
	logic [CountW-1:0] n_c;

	logic                v_s1, v_s2;
	logic [PosW-1:0]     t_s1;
	logic [CountW-1:0]   n_s1;
	logic [MaxStops-1:0] eq_s1, gt_s1;
	lerp_req_t           req_s2;
	lerp_req_t           r_c;
	logic [PosW-1:0]     m_c;
	logic                done_c;
	logic                rdy_s1, rdy_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			for (int i = 0; i < MaxStops; i++) stop_q[i] <= '0;
		end else if (wr_en) begin
			if (wr_index == RegCount) count_q <= wr_data[CountW-1:0];
			for (int i = 0; i < MaxStops; i++) begin
				if (wr_index == CfgIdxW'(int'(RegStop0) + i)) stop_q[i] <= wr_data;
			end
		end
	end

	always_comb begin
		for (int i = 0; i < MaxStops; i++) begin
			sp[i] = stop_q[i][StopW-1:ColW];
			sc[i] = stop_q[i][ColW-1:0];
		end
		n_c = (count_q > CountW'(MaxStops)) ? CountW'(MaxStops) : count_q;
	end

	assign rdy_s2    = !v_s2 || req_ready;
	assign rdy_s1    = !v_s1 || rdy_s2;
	assign pos.ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= pos.valid;
			if (rdy_s2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && pos.valid) begin
			t_s1 <= pos.position;
			n_s1 <= n_c;
			for (int i = 0; i < MaxStops; i++) begin
				eq_s1[i] <= sp[i] == pos.position;
				gt_s1[i] <= sp[i] > pos.position;
			end
		end
		if (rdy_s2 && v_s1) req_s2 <= r_c;
	end

	always_comb begin
		r_c.ca  = '0;
		r_c.cb  = '0;
		r_c.num = '0;
		r_c.den = PosW'(1);
		m_c     = (sp[1] > sp[0]) ? sp[1] : sp[0];
		done_c  = 1'b0;
		case (n_s1)
			3'd0: begin
			end
			3'd1: begin
				r_c.ca = sc[0];
			end
			3'd2: begin
				r_c.ca = sc[0];
				if (m_c != '0) begin
					r_c.cb  = sc[1];
					r_c.num = t_s1;
					r_c.den = m_c;
				end
			end
			default: begin
				for (int i = 0; i < MaxStops; i++) begin
					if (CountW'(i + 1) == n_s1) r_c.ca = sc[i];
				end
				for (int i = 0; i < MaxStops; i++) begin
					if (!done_c && (CountW'(i) < n_s1)) begin
						if (eq_s1[i]) begin
							r_c.ca = sc[i];
							done_c = 1'b1;
						end else if (gt_s1[i]) begin
							done_c = 1'b1;
							if (i == 0) begin
								r_c.ca = sc[0];
							end else begin
								r_c.ca  = sc[i-1];
								r_c.cb  = sc[i];
								r_c.num = t_s1 - sp[i-1];
								r_c.den = sp[i] - sp[i-1];
							end
						end
					end
				end
			end
		endcase
	end

	assign req_valid = v_s2;
	assign req       = req_s2;
endmodule

// File: rtl/core/mscg_lerp.sv
// Channel interpolation: products, sum, scaling and a bit-per-stage divider.
`include "multi_stop_color_gradient_core_defines.svh"
module mscg_lerp import mscg_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_ready,
	input  lerp_req_t   req,
	mscg_color_if.source col
);
	logic                    v_s3, v_s4, v_s5;
	logic                    rdy_s3, rdy_s4, rdy_s5;
	logic [PosW-1:0]         den_s3, den_s4, den_s5;
	logic [ProdW-1:0]        p1_s3  [NumCh];
	logic signed [ValW-1:0]  p2_s3  [NumCh];
	logic signed [ValW-1:0]  val_s4 [NumCh];
	logic [RemW-1:0]         rem_s5 [NumCh];
	logic [NumCh-1:0]        zero_s5, ovf_s5;

	logic [ProdW-1:0]        pa_c  [NumCh];
	logic signed [ValW-1:0]  pb_c  [NumCh];
	logic signed [ChanW:0]   diff_c[NumCh];
	logic signed [ValW-1:0]  sum_c [NumCh];
	logic [RemW-1:0]         n_c   [NumCh];

	logic                    dv_v_s   [DivSteps];
	logic                    dv_rdy   [DivSteps];
	logic [PosW-1:0]         dv_den_s [DivSteps];
	logic [RemW-1:0]         dv_rem_s [DivSteps][NumCh];
	logic [ChanW-1:0]        dv_q_s   [DivSteps][NumCh];
	logic [NumCh-1:0]        dv_z_s   [DivSteps];
	logic [NumCh-1:0]        dv_o_s   [DivSteps];

	logic                    pv   [DivSteps];
	logic [PosW-1:0]         pden [DivSteps];
	logic [RemW-1:0]         prem [DivSteps][NumCh];
	logic [ChanW-1:0]        pq   [DivSteps][NumCh];
	logic [NumCh-1:0]        pz   [DivSteps];
	logic [NumCh-1:0]        po   [DivSteps];
	logic [ChanW-1:0]        res_c[NumCh];
	logic [NumCh-1:0]        rem_ok;

	assign rdy_s5    = !v_s5 || dv_rdy[0];
	assign rdy_s4    = !v_s4 || rdy_s5;
	assign rdy_s3    = !v_s3 || rdy_s4;
	assign req_ready = rdy_s3;

	always_comb begin
		for (int c = 0; c < NumCh; c++) begin
			diff_c[c] = $signed({1'b0, req.cb[c*ChanW +: ChanW]})
				- $signed({1'b0, req.ca[c*ChanW +: ChanW]});
			pa_c[c]   = req.ca[c*ChanW +: ChanW] * req.den;
			pb_c[c]   = $signed({1'b0, req.num}) * diff_c[c];
			sum_c[c]  = $signed({2'b00, p1_s3[c]}) + p2_s3[c];
			n_c[c]    = RemW'({val_s4[c][ValW-2:0], 1'b0}) + RemW'(den_s4);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy_s3) v_s3 <= req_valid;
			if (rdy_s4) v_s4 <= v_s3;
			if (rdy_s5) v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s3 && req_valid) begin
			den_s3 <= req.den;
			for (int c = 0; c < NumCh; c++) begin
				p1_s3[c] <= pa_c[c];
				p2_s3[c] <= pb_c[c];
			end
		end
		if (rdy_s4 && v_s3) begin
			den_s4 <= den_s3;
			for (int c = 0; c < NumCh; c++) val_s4[c] <= sum_c[c];
		end
		if (rdy_s5 && v_s4) begin
			den_s5 <= den_s4;
			for (int c = 0; c < NumCh; c++) begin
				rem_s5[c]  <= n_c[c];
				zero_s5[c] <= val_s4[c][ValW-1] || (val_s4[c] == '0);
				ovf_s5[c]  <= n_c[c] >= RemW'({den_s4, {(ChanW + 1){1'b0}}});
			end
		end
	end

	for (genvar j = 0; j < DivSteps; j++) begin : g_div
		if (j == 0) begin : g_first
			always_comb begin
				pv[j]   = v_s5;
				pden[j] = den_s5;
				pz[j]   = zero_s5;
				po[j]   = ovf_s5;
				for (int c = 0; c < NumCh; c++) begin
					prem[j][c] = rem_s5[c];
					pq[j][c]   = '0;
				end
			end
		end else begin : g_next
			always_comb begin
				pv[j]   = dv_v_s[j-1];
				pden[j] = dv_den_s[j-1];
				pz[j]   = dv_z_s[j-1];
				po[j]   = dv_o_s[j-1];
				for (int c = 0; c < NumCh; c++) begin
					prem[j][c] = dv_rem_s[j-1][c];
					pq[j][c]   = dv_q_s[j-1][c];
				end
			end
		end

		if (j == DivSteps - 1) begin : g_last
			assign dv_rdy[j] = !dv_v_s[j] || col.ready;
		end else begin : g_mid
			assign dv_rdy[j] = !dv_v_s[j] || dv_rdy[j+1];
		end

		logic [RemW-1:0] sh_c;
		assign sh_c = RemW'({pden[j], 1'b0}) << (DivSteps - 1 - j);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v_s[j] <= 1'b0;
			end else if (dv_rdy[j]) begin
				dv_v_s[j] <= pv[j];
			end
		end

		always_ff @(posedge clk) begin
			if (dv_rdy[j] && pv[j]) begin
				dv_den_s[j] <= pden[j];
				dv_z_s[j]   <= pz[j];
				dv_o_s[j]   <= po[j];
				for (int c = 0; c < NumCh; c++) begin
					if (prem[j][c] >= sh_c) begin
						dv_rem_s[j][c] <= prem[j][c] - sh_c;
						dv_q_s[j][c]   <= pq[j][c] | (ChanW'(1) << (DivSteps - 1 - j));
					end else begin
						dv_rem_s[j][c] <= prem[j][c];
						dv_q_s[j][c]   <= pq[j][c];
					end
				end
			end
		end
	end

	always_comb begin
		for (int c = 0; c < NumCh; c++) begin
			if (dv_z_s[DivSteps-1][c]) begin
				res_c[c] = '0;
			end else if (dv_o_s[DivSteps-1][c]) begin
				res_c[c] = '1;
			end else begin
				res_c[c] = dv_q_s[DivSteps-1][c];
			end
			rem_ok[c] = dv_z_s[DivSteps-1][c] || dv_o_s[DivSteps-1][c]
				|| (dv_rem_s[DivSteps-1][c] < RemW'({dv_den_s[DivSteps-1], 1'b0}));
		end
	end

	assign col.valid = dv_v_s[DivSteps-1];
	assign col.red   = res_c[0];
	assign col.green = res_c[1];
	assign col.blue  = res_c[2];
	assign col.alpha = res_c[3];

	`MSCG_ASSERT_IMP(a_den_nonzero, req_valid, req.den != '0)
	`MSCG_ASSERT_NXT(a_s5_hold, v_s5 && !rdy_s5, v_s5 && $stable(rem_s5[0]))
	`MSCG_ASSERT_IMP(a_rem_bound, dv_v_s[DivSteps-1], &rem_ok)
endmodule

// File: rtl/core/multi_stop_color_gradient_core.sv
// A colour is presented once its position has been accepted and has passed
// through thirteen register stages.
// Throughput: one position per cycle; the thirteen register stages each stall
// only when they hold data that the next stage cannot take.
// The divider resolves one quotient bit per stage over eight stages.
// Reset clears the stop count, every stop register and all stage valid bits.
module multi_stop_color_gradient_core import mscg_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_en,
	input  logic [CfgIdxW-1:0] wr_index,
	input  logic [StopW-1:0]   wr_data,
	mscg_pos_if.sink           pos,
	mscg_color_if.source       color
);
	logic      req_valid;
	logic      req_ready;
	lerp_req_t req;

	mscg_select u_select (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (wr_en),
		.wr_index  (wr_index),
		.wr_data   (wr_data),
		.pos       (pos),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req)
	);

	mscg_lerp u_lerp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.col       (color)
	);
endmodule
